@@ design/pbtp_pkg.sv @@
`timescale 1ns / 1ps

package pbtp_pkg;

  localparam logic [3:0] REG_MAT_A  = 4'd0;
  localparam logic [3:0] REG_MAT_B  = 4'd1;
  localparam logic [3:0] REG_MAT_C  = 4'd2;
  localparam logic [3:0] REG_MAT_D  = 4'd3;
  localparam logic [3:0] REG_MAT_DX = 4'd4;
  localparam logic [3:0] REG_MAT_DY = 4'd5;
  localparam logic [3:0] REG_PEN    = 4'd6;
  localparam logic [3:0] REG_MITER  = 4'd7;

  localparam logic signed [31:0] FIX_ONE = 32'sd65536;
  // 2.2 in Q16.16.
  localparam logic [17:0] CAP_FACTOR = 18'd144179;
  localparam logic [1:0] SEEN_MAX = 2'd3;

  typedef struct packed {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic               has_point;
    logic               last;
  } point_word_t;

  typedef struct packed {
    logic signed [31:0] box_x;
    logic signed [31:0] box_y;
    logic signed [31:0] box_w;
    logic signed [31:0] box_h;
  } box_word_t;

  typedef struct packed {
    logic [3:0]  index;
    logic [31:0] value;
  } cfg_word_t;

  typedef struct packed {
    logic signed [31:0] mat_a;
    logic signed [31:0] mat_b;
    logic signed [31:0] mat_c;
    logic signed [31:0] mat_d;
    logic signed [31:0] mat_dx;
    logic signed [31:0] mat_dy;
    logic [30:0]        pen;
    logic [15:0]        miter;
    logic               cap;
  } regs_t;

  typedef struct packed {
    logic signed [31:0] lx;
    logic signed [31:0] ly;
    logic signed [31:0] hx;
    logic signed [31:0] hy;
    logic [1:0]         seen;
  } bounds_t;

endpackage

@@ design/pbtp_chan_if.sv @@
`timescale 1ns / 1ps

interface pbtp_chan_if #(parameter type word_t = logic);
  logic  valid;
  logic  ready;
  word_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ design/pbtp_bounds.sv @@
`timescale 1ns / 1ps

module pbtp_bounds import pbtp_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  pbtp_chan_if.sink points,
  output logic    s_valid,
  output bounds_t s_data,
  input  logic    s_ready
);

  bounds_t acc;
  bounds_t acc_next;
  logic    accept;

  assign points.ready = !s_valid || s_ready;
  assign accept = points.valid && points.ready;

  always_comb begin
    acc_next = acc;
    if (points.data.has_point) begin
      if (acc.seen == 2'd0) begin
        acc_next.lx = points.data.px;
        acc_next.hx = points.data.px;
        acc_next.ly = points.data.py;
        acc_next.hy = points.data.py;
      end else begin
        if (points.data.px < acc.lx) acc_next.lx = points.data.px;
        if (points.data.px > acc.hx) acc_next.hx = points.data.px;
        if (points.data.py < acc.ly) acc_next.ly = points.data.py;
        if (points.data.py > acc.hy) acc_next.hy = points.data.py;
      end
      if (acc.seen != SEEN_MAX) acc_next.seen = acc.seen + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
      s_valid <= 1'b0;
    end else begin
      if (accept && points.data.last) begin
        s_valid <= 1'b1;
      end else if (s_ready) begin
        s_valid <= 1'b0;
      end
      if (accept) begin
        if (points.data.last) begin
          acc <= '0;
        end else begin
          acc <= acc_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && points.data.last) s_data <= acc_next;
  end

endmodule

@@ design/pbtp_xform.sv @@
`timescale 1ns / 1ps

module pbtp_xform import pbtp_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  regs_t   regs,
  input  logic    s_valid,
  input  bounds_t s_data,
  output logic    s_ready,
  pbtp_chan_if.source box
);

  function automatic logic signed [63:0] mul_s(input logic signed [31:0] a,
                                               input logic signed [31:0] b);
    return 64'(a) * 64'(b);
  endfunction

  // Rounds the sum of two Q32.32 products to Q16.16, then adds the offset.
  function automatic logic signed [49:0] round_sum(input logic signed [63:0] p1,
                                                   input logic signed [63:0] p2,
                                                   input logic signed [31:0] t);
    logic signed [65:0] s;
    logic signed [48:0] r;
    s = 66'(p1) + 66'(p2) + 66'sd32768;
    r = s[64:16];
    return 50'(r) + 50'(t);
  endfunction

  // Extent times the magnitude of a matrix entry, from the two corner products.
  function automatic logic [62:0] ext_mag(input logic signed [63:0] lo,
                                          input logic signed [63:0] hi,
                                          input logic               neg);
    logic signed [63:0] d;
    d = neg ? (lo - hi) : (hi - lo);
    return d[62:0];
  endfunction

  function automatic logic signed [49:0] min2(input logic signed [49:0] a,
                                              input logic signed [49:0] b);
    return (a < b) ? a : b;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [51:0] v);
    if (v > 52'sd2147483647) return 32'sh7fffffff;
    if (v < -52'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  logic r_out, r2, r3, r4;
  logic v2, v3, v4, out_valid;

  // Product stage.
  logic signed [63:0] p_lxa, p_hxa, p_lyc, p_hyc;
  logic signed [63:0] p_lxb, p_hxb, p_lyd, p_hyd;
  logic [46:0]        pen_m;
  logic [48:0]        pen_cap;
  logic [1:0]         seen2;

  // Corner and extent stage.
  logic signed [49:0] cx3 [4];
  logic signed [49:0] cy3 [4];
  logic [62:0]        wa3, hc3, hd3, wb3;
  logic [38:0]        pq3;
  logic               empty3;
  logic [53:0]        half;
  logic [53:0]        miter_half;
  logic [54:0]        half_round;

  // Reduction stage.
  logic signed [49:0] cx4, cy4;
  logic [48:0]        bw4, bh4;
  logic [38:0]        pq4;
  logic               empty4;
  logic [63:0]        bw_sum, bh_sum;

  logic signed [51:0] pq_s;
  box_word_t          res;

  assign r_out = !out_valid || box.ready;
  assign r4 = !v4 || r_out;
  assign r3 = !v3 || r4;
  assign r2 = !v2 || r3;
  assign s_ready = r2;
  assign box.valid = out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (r2) v2 <= s_valid;
      if (r3) v3 <= v2;
      if (r4) v4 <= v3;
      if (r_out) out_valid <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (r2) begin
      p_lxa <= mul_s(s_data.lx, regs.mat_a);
      p_hxa <= mul_s(s_data.hx, regs.mat_a);
      p_lyc <= mul_s(s_data.ly, regs.mat_c);
      p_hyc <= mul_s(s_data.hy, regs.mat_c);
      p_lxb <= mul_s(s_data.lx, regs.mat_b);
      p_hxb <= mul_s(s_data.hx, regs.mat_b);
      p_lyd <= mul_s(s_data.ly, regs.mat_d);
      p_hyd <= mul_s(s_data.hy, regs.mat_d);
      pen_m <= 47'(regs.pen) * 47'(regs.miter);
      pen_cap <= 49'(regs.pen) * 49'(CAP_FACTOR);
      seen2 <= s_data.seen;
    end
  end

  always_comb begin
    half = 54'({regs.pen, 15'd0});
    miter_half = {pen_m, 7'd0};
    if (seen2 == SEEN_MAX && miter_half > half) half = miter_half;
    if (regs.cap && 54'(pen_cap) > half) half = 54'(pen_cap);
    half_round = 55'(half) + 55'd32768;
  end

  always_ff @(posedge clk) begin
    if (r3) begin
      cx3[0] <= round_sum(p_lxa, p_lyc, regs.mat_dx);
      cx3[1] <= round_sum(p_lxa, p_hyc, regs.mat_dx);
      cx3[2] <= round_sum(p_hxa, p_hyc, regs.mat_dx);
      cx3[3] <= round_sum(p_hxa, p_lyc, regs.mat_dx);
      cy3[0] <= round_sum(p_lxb, p_lyd, regs.mat_dy);
      cy3[1] <= round_sum(p_lxb, p_hyd, regs.mat_dy);
      cy3[2] <= round_sum(p_hxb, p_hyd, regs.mat_dy);
      cy3[3] <= round_sum(p_hxb, p_lyd, regs.mat_dy);
      wa3 <= ext_mag(p_lxa, p_hxa, regs.mat_a[31]);
      hc3 <= ext_mag(p_lyc, p_hyc, regs.mat_c[31]);
      hd3 <= ext_mag(p_lyd, p_hyd, regs.mat_d[31]);
      wb3 <= ext_mag(p_lxb, p_hxb, regs.mat_b[31]);
      pq3 <= half_round[54:16];
      empty3 <= (seen2 == 2'd0);
    end
  end

  assign bw_sum = 64'(hc3) + 64'(wa3) + 64'd32768;
  assign bh_sum = 64'(hd3) + 64'(wb3) + 64'd32768;

  always_ff @(posedge clk) begin
    if (r4) begin
      cx4 <= min2(min2(cx3[0], cx3[1]), min2(cx3[2], cx3[3]));
      cy4 <= min2(min2(cy3[0], cy3[1]), min2(cy3[2], cy3[3]));
      bw4 <= bw_sum[63:15] >> 1;
      bh4 <= bh_sum[63:15] >> 1;
      pq4 <= pq3;
      empty4 <= empty3;
    end
  end

  always_comb begin
    pq_s = $signed({13'd0, pq4});
    if (empty4) begin
      res = '0;
    end else begin
      res.box_x = sat32(52'(cx4) - pq_s);
      res.box_y = sat32(52'(cy4) - pq_s);
      res.box_w = sat32($signed({3'd0, bw4}) + (pq_s <<< 1));
      res.box_h = sat32($signed({3'd0, bh4}) + (pq_s <<< 1));
    end
  end

  always_ff @(posedge clk) begin
    if (r_out) box.data <= res;
  end

endmodule

@@ design/path_bounds_with_transform_and_pen_top.sv @@
`timescale 1ns / 1ps

// Bounding box of a path, taken through an affine matrix and widened by a pen.
// Points arrive as words on the points channel (valid/ready, Q16.16 px and py,
// has_point, last). One point word is accepted every cycle unless the pipeline
// behind it stalls. A word marked last closes the path, and one box word (box_x,
// box_y, box_w, box_h, Q16.16, saturated) leaves on the box channel for it;
// a path with no point gives an all-zero box. The box is computed in a
// four-stage pipeline (products, corners and extents, minimum and rounding,
// pen and saturation), so a new path can close every cycle while the receiver
// takes boxes. When the receiver stalls, finished boxes wait in the pipeline
// stages, and points are taken until every stage and the bounds register is full.
// The cfg channel writes the matrix, pen width and miter/cap register by index
// and is always ready; the user must write it only while no path is in flight,
// which the block does not enforce. Synchronous reset loads the identity
// matrix, clears the pen, empties the pipeline and starts a fresh path.
module path_bounds_with_transform_and_pen_top import pbtp_pkg::*; (
  input logic clk,
  input logic rst,
  pbtp_chan_if.sink points,
  pbtp_chan_if.sink cfg,
  pbtp_chan_if.source box
);

  regs_t   regs;
  logic    s_valid;
  logic    s_ready;
  bounds_t s_data;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.mat_a <= FIX_ONE;
      regs.mat_b <= '0;
      regs.mat_c <= '0;
      regs.mat_d <= FIX_ONE;
      regs.mat_dx <= '0;
      regs.mat_dy <= '0;
      regs.pen <= '0;
      regs.miter <= '0;
      regs.cap <= 1'b0;
    end else if (cfg.valid) begin
      case (cfg.data.index)
        REG_MAT_A:  regs.mat_a <= cfg.data.value;
        REG_MAT_B:  regs.mat_b <= cfg.data.value;
        REG_MAT_C:  regs.mat_c <= cfg.data.value;
        REG_MAT_D:  regs.mat_d <= cfg.data.value;
        REG_MAT_DX: regs.mat_dx <= cfg.data.value;
        REG_MAT_DY: regs.mat_dy <= cfg.data.value;
        REG_PEN:    regs.pen <= cfg.data.value[30:0];
        REG_MITER: begin
          regs.miter <= cfg.data.value[15:0];
          regs.cap <= cfg.data.value[16];
        end
        default: ;
      endcase
    end
  end

  pbtp_bounds u_bounds (
    .clk     (clk),
    .rst     (rst),
    .points  (points),
    .s_valid (s_valid),
    .s_data  (s_data),
    .s_ready (s_ready)
  );

  pbtp_xform u_xform (
    .clk     (clk),
    .rst     (rst),
    .regs    (regs),
    .s_valid (s_valid),
    .s_data  (s_data),
    .s_ready (s_ready),
    .box     (box)
  );

endmodule
